@@ hw/rtl/stpd_pkg.sv @@
// types and constants shared by the stuffed packet deframer
`default_nettype none
package stpd_pkg;

  typedef enum logic [3:0] {
    KIND_IGNORED  = 4'd0,
    KIND_START    = 4'd1,
    KIND_ESCAPE   = 4'd2,
    KIND_STORED   = 4'd3,
    KIND_BYTE     = 4'd4,
    KIND_EMPTY    = 4'd5,
    KIND_BADSUM   = 4'd6,
    KIND_OVERFLOW = 4'd7,
    KIND_LINEERR  = 4'd8
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  localparam logic [1:0] CFG_START_CODE  = 2'd0;
  localparam logic [1:0] CFG_END_CODE    = 2'd1;
  localparam logic [1:0] CFG_ESCAPE_CODE = 2'd2;

  localparam logic [7:0] START_CODE_RST  = 8'h55;
  localparam logic [7:0] END_CODE_RST    = 8'hAA;
  localparam logic [7:0] ESCAPE_CODE_RST = 8'h5A;

  localparam int unsigned LEN_W = 7;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       framing_error;
    logic       overrun_error;
  } in_item_t;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] length;
    logic             last;
  } out_item_t;

  // per-cell control: write the shared byte here, or take the neighbor's byte
  typedef struct packed {
    logic store;
    logic shift;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ hw/rtl/stpd_if.sv @@
// handshake interfaces for the input, result and configuration channels
`default_nettype none
interface stpd_in_if import stpd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface stpd_out_if import stpd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface stpd_cfg_if ();
  logic       valid;
  logic       ready;
  logic [1:0] addr;
  logic [7:0] wdata;
  modport source (output valid, output addr, output wdata, input ready);
  modport sink (input valid, input addr, input wdata, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/stpd_cell.sv @@
// one byte cell of the packet store chain
`default_nettype none
module stpd_cell import stpd_pkg::*; (
  input  wire logic       clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire logic [7:0] wr_data_i,
  input  wire logic [7:0] next_i,
  output logic [7:0]      data_o
);

  logic [7:0] data_q;
  logic [7:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.store) begin
      data_d = wr_data_i;
    end else if (ctrl_i.shift) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

@@ hw/rtl/stuffed_packet_deframer_unit.sv @@
// A result is registered and shown in the cycle after its item is accepted.
// Throughput: one item per cycle unless output stalls; a good close of N stored
// bytes emits them one per cycle from the head of the cell chain, holding input.
// Output stalls hold input only while the single result register is full.
// Reset (async, active low): packet, escape, sum and count cleared, codes back
// to 0x55/0xAA/0x5A; the cell chain contents stay undefined.
`default_nettype none
module stuffed_packet_deframer_unit import stpd_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 4
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  stpd_in_if.sink     in_i,
  stpd_out_if.source  out_o,
  stpd_cfg_if.sink    cfg_i
);

  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);

  // configuration
  logic [7:0] start_code_q, end_code_q, escape_code_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_code_q  <= START_CODE_RST;
      end_code_q    <= END_CODE_RST;
      escape_code_q <= ESCAPE_CODE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.addr)
        CFG_START_CODE:  start_code_q  <= cfg_i.wdata;
        CFG_END_CODE:    end_code_q    <= cfg_i.wdata;
        CFG_ESCAPE_CODE: escape_code_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // control state
  state_e         state_q, state_d;
  logic           in_pkt_q, in_pkt_d;
  logic           esc_q, esc_d;
  logic [7:0]     sum_q, sum_d;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  rem_q, rem_d;
  logic           out_valid_q, out_valid_d;
  out_item_t      out_q, out_d;

  logic           out_free;
  logic           accept;
  logic           do_store;
  logic           do_shift;
  logic [7:0]     head_data;

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == ST_IDLE) && out_free;
  assign accept      = in_i.valid && in_i.ready;

  // cell chain
  logic [7:0] cell_data [BUFFER_DEPTH];

  for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
    cell_ctrl_t ctrl;
    logic [7:0] next;
    assign ctrl.store = do_store && (count_q == CW'(i));
    assign ctrl.shift = do_shift;
    if (i == BUFFER_DEPTH - 1) begin : g_tail
      assign next = 8'h00;
    end else begin : g_mid
      assign next = cell_data[i+1];
    end
    stpd_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .wr_data_i (in_i.payload.rx_byte),
      .next_i    (next),
      .data_o    (cell_data[i])
    );
  end

  assign head_data = cell_data[0];

  always_comb begin
    logic [7:0] b;
    b           = in_i.payload.rx_byte;
    state_d     = state_q;
    in_pkt_d    = in_pkt_q;
    esc_d       = esc_q;
    sum_d       = sum_q;
    count_d     = count_q;
    rem_d       = rem_q;
    do_store    = 1'b0;
    do_shift    = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;

    if (state_q == ST_DRAIN) begin
      if (out_free) begin
        out_valid_d  = 1'b1;
        out_d.kind   = KIND_BYTE;
        out_d.data   = head_data;
        out_d.length = LEN_W'(count_q);
        out_d.last   = (rem_q == CW'(1));
        do_shift     = 1'b1;
        rem_d        = rem_q - CW'(1);
        if (rem_q == CW'(1)) begin
          state_d = ST_IDLE;
        end
      end
    end else if (accept) begin
      out_valid_d  = 1'b1;
      out_d.data   = b;
      out_d.length = LEN_W'(count_q);
      out_d.last   = 1'b1;
      if (in_i.payload.framing_error || in_i.payload.overrun_error) begin
        in_pkt_d   = 1'b0;
        out_d.kind = KIND_LINEERR;
      end else if (!esc_q && b == start_code_q) begin
        in_pkt_d     = 1'b1;
        sum_d        = 8'h00;
        count_d      = '0;
        out_d.kind   = KIND_START;
        out_d.length = '0;
      end else if (!esc_q && b == escape_code_q) begin
        esc_d      = 1'b1;
        out_d.kind = KIND_ESCAPE;
      end else if (!esc_q && b == end_code_q) begin
        if (!in_pkt_q) begin
          out_d.kind = KIND_IGNORED;
        end else if (sum_q != 8'h00) begin
          out_d.kind = KIND_BADSUM;
        end else if (count_q == '0) begin
          in_pkt_d     = 1'b0;
          out_d.kind   = KIND_EMPTY;
          out_d.length = '0;
        end else begin
          // first stored byte goes out now, the rest drain from the chain head
          in_pkt_d   = 1'b0;
          out_d.kind = KIND_BYTE;
          out_d.data = head_data;
          out_d.last = (count_q == CW'(1));
          do_shift   = 1'b1;
          rem_d      = count_q - CW'(1);
          if (count_q != CW'(1)) begin
            state_d = ST_DRAIN;
          end
        end
      end else begin
        esc_d = 1'b0;
        if (!in_pkt_q) begin
          out_d.kind = KIND_IGNORED;
        end else if (count_q < CW'(BUFFER_DEPTH)) begin
          do_store     = 1'b1;
          count_d      = count_q + CW'(1);
          sum_d        = sum_q + b;
          out_d.kind   = KIND_STORED;
          out_d.length = LEN_W'(count_q + CW'(1));
        end else begin
          in_pkt_d   = 1'b0;
          out_d.kind = KIND_OVERFLOW;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_pkt_q    <= 1'b0;
      esc_q       <= 1'b0;
      sum_q       <= 8'h00;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_pkt_q    <= in_pkt_d;
      esc_q       <= esc_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

`ifndef ASSERT_OFF
  a_drain_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> rem_q != '0 && rem_q < count_q)
    else $error("drain remainder out of range");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(BUFFER_DEPTH))
    else $error("byte count past buffer depth");

  a_drain_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN && out_valid_q |-> out_q.kind == KIND_BYTE && !out_q.last)
    else $error("pending result during drain is not a non-final packet byte");

  a_drain_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> !in_i.ready)
    else $error("input taken while draining");
`endif

endmodule
`default_nettype wire
